FILE: design/pls_pkg.sv
package pls_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_GET    = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

endpackage

FILE: design/pls_ram.sv
module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/positional_list_store_unit.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_req_type, in_position, in_value
// out_      output     out_valid / out_stall  out_status, out_read_value, out_count
//
// A clear or a rejected item goes straight to the response state; a get, an insert or a
// remove first walks the list from the header one link per cycle through the link memory's
// read port; a get then reads the value and an insert or a remove rewrites the links.
// Reset (rst_n low, synchronous) empties the list at once; no clearing pass is needed.
// A waiting result does not stop the walk of the next item, only its final hand-off.
module positional_list_store_unit import pls_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_req_type,
  input  logic [$clog2(CAPACITY+1)-1:0]     in_position,
  input  logic signed [DATA_WIDTH-1:0]      in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic signed [DATA_WIDTH-1:0]      out_read_value,
  output logic [$clog2(CAPACITY+1)-1:0]     out_count
);

  localparam int LINK_W = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = LINK_W + 1;
  // The header node is the index just past the last node.
  localparam logic [LINK_W-1:0] HDR = LINK_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_GETV,
    S_INS_A,
    S_INS_B,
    S_RM_A,
    S_RM_B,
    S_RESP
  } state_t;

  state_t                  state_r;
  req_t                    kind_r;
  status_t                 st_r;
  logic signed [DATA_WIDTH-1:0] val_r;
  logic signed [DATA_WIDTH-1:0] rd_r;
  logic [LINK_W-1:0]       count_r;
  logic [LINK_W-1:0]       head_r;
  logic [LINK_W-1:0]       free_head_r;
  logic [LINK_W-1:0]       free_nxt_r;
  logic [LINK_W-1:0]       fill_r;
  logic [LINK_W-1:0]       nn_r;
  logic [LINK_W-1:0]       cur_r;
  logic [LINK_W-1:0]       prev_r;
  logic [LINK_W-1:0]       prev2_r;
  logic [CNT_W-1:0]        rem_r;
  logic                    first_r;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic signed [DATA_WIDTH-1:0] out_read_value_r;
  logic [LINK_W-1:0]       out_count_r;

  logic [LINK_W-1:0]       step_nxt;
  logic                    link_we;
  logic [IDX_W-1:0]        link_waddr;
  logic [LINK_W-1:0]       link_wdata;
  logic [IDX_W-1:0]        link_raddr;
  logic [LINK_W-1:0]       link_rdata;
  logic                    val_we;
  logic [IDX_W-1:0]        val_raddr;
  logic [DATA_WIDTH-1:0]   val_rdata;

  pls_ram #(
    .WIDTH (LINK_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  pls_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (nn_r[IDX_W-1:0]),
    .wdata (val_r),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // The header's forward link lives in head_r; every other link comes from memory
  // read in the previous cycle at the current node.
  always_comb begin
    step_nxt   = (cur_r == HDR) ? head_r : link_rdata;
    link_raddr = (state_r == S_WALK) ? step_nxt[IDX_W-1:0] : free_head_r[IDX_W-1:0];
    val_raddr  = step_nxt[IDX_W-1:0];
    link_we    = 1'b0;
    link_waddr = nn_r[IDX_W-1:0];
    link_wdata = cur_r;
    val_we     = 1'b0;
    unique case (state_r)
      S_INS_A: begin
        link_we = 1'b1;
        val_we  = 1'b1;
      end
      S_INS_B: begin
        link_we    = (prev_r != HDR);
        link_waddr = prev_r[IDX_W-1:0];
        link_wdata = nn_r;
      end
      S_RM_A: begin
        link_we    = 1'b1;
        link_waddr = prev_r[IDX_W-1:0];
        link_wdata = free_head_r;
      end
      S_RM_B: begin
        link_we    = (prev2_r != HDR);
        link_waddr = prev2_r[IDX_W-1:0];
        link_wdata = cur_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= HDR;
      free_head_r <= HDR;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The response state sets the valid itself when it hands off a new item.
      if (out_valid_r && !out_stall && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= req_t'(in_req_type);
            val_r   <= in_value;
            rd_r    <= '0;
            cur_r   <= HDR;
            prev_r  <= HDR;
            prev2_r <= HDR;
            first_r <= 1'b1;
            // Recycled nodes go first; untouched nodes are handed out by fill_r.
            nn_r    <= (free_head_r != HDR) ? free_head_r : fill_r;
            unique case (req_t'(in_req_type))
              REQ_INSERT: begin
                if (in_position > count_r) begin
                  st_r    <= ST_RANGE;
                  state_r <= S_RESP;
                end else if (count_r == HDR) begin
                  st_r    <= ST_FULL;
                  state_r <= S_RESP;
                end else begin
                  st_r    <= ST_OK;
                  rem_r   <= CNT_W'(in_position) + CNT_W'(1);
                  state_r <= S_WALK;
                end
              end
              REQ_REMOVE: begin
                if (count_r == '0) begin
                  st_r    <= ST_EMPTY;
                  state_r <= S_RESP;
                end else if (in_position >= count_r) begin
                  st_r    <= ST_RANGE;
                  state_r <= S_RESP;
                end else begin
                  st_r    <= ST_OK;
                  rem_r   <= CNT_W'(in_position) + CNT_W'(2);
                  state_r <= S_WALK;
                end
              end
              REQ_GET: begin
                if (in_position >= count_r) begin
                  st_r    <= ST_RANGE;
                  state_r <= S_RESP;
                end else begin
                  st_r    <= ST_OK;
                  rem_r   <= CNT_W'(in_position) + CNT_W'(1);
                  state_r <= S_WALK;
                end
              end
              REQ_CLEAR: begin
                head_r      <= HDR;
                free_head_r <= HDR;
                fill_r      <= '0;
                count_r     <= '0;
                st_r        <= ST_OK;
                state_r     <= S_RESP;
              end
              default: begin
                st_r    <= ST_OK;
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_WALK: begin
          // The first cycle also sees the link of the free-list head read at accept.
          first_r <= 1'b0;
          if (first_r) begin
            free_nxt_r <= link_rdata;
          end
          prev2_r <= prev_r;
          prev_r  <= cur_r;
          cur_r   <= step_nxt;
          rem_r   <= rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            unique case (kind_r)
              REQ_INSERT: state_r <= S_INS_A;
              REQ_REMOVE: state_r <= S_RM_A;
              default:    state_r <= S_GETV;
            endcase
          end
        end
        S_GETV: begin
          rd_r    <= val_rdata;
          state_r <= S_RESP;
        end
        S_INS_A: begin
          if (free_head_r != HDR) begin
            free_head_r <= free_nxt_r;
          end else begin
            fill_r <= fill_r + LINK_W'(1);
          end
          state_r <= S_INS_B;
        end
        S_INS_B: begin
          if (prev_r == HDR) begin
            head_r <= nn_r;
          end
          count_r <= count_r + LINK_W'(1);
          state_r <= S_RESP;
        end
        S_RM_A: begin
          free_head_r <= prev_r;
          state_r     <= S_RM_B;
        end
        S_RM_B: begin
          if (prev2_r == HDR) begin
            head_r <= cur_r;
          end
          count_r <= count_r - LINK_W'(1);
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r      <= 1'b1;
            out_status_r     <= st_r;
            out_read_value_r <= rd_r;
            out_count_r      <= count_r;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;

endmodule
